FILE: rtl/tlpq_pkg.sv
// Shared types and constants for the three-level priority queue.
`default_nettype none

package tlpq_pkg;

    // Number of priority levels (level 1 highest).
    localparam int LEVELS        = 3;
    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int VALUE_W  = 8;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;

    // Packed bus widths, rounded up to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Request kinds carried in s_tuser
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;     // execute the request on the input bus
    } dp_cmd_t;

endpackage : tlpq_pkg

`default_nettype wire

FILE: rtl/tlpq_ctrl.sv
// Request sequencer: accepts one request, then holds its response until taken.
`default_nettype none

module tlpq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output tlpq_pkg::dp_cmd_t        cmd
);
    import tlpq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : tlpq_ctrl

`default_nettype wire

FILE: rtl/tlpq_datapath.sv
// Level pointers, fill counts, shared byte store and response registers.
`default_nettype none

module tlpq_datapath #(
    parameter int DEPTH = tlpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  tlpq_pkg::dp_cmd_t                    cmd,
    input  wire logic                            req_command,
    input  wire logic [tlpq_pkg::VALUE_W-1:0]    req_value,
    input  wire logic [tlpq_pkg::LEVEL_W-1:0]    req_level,
    output logic [tlpq_pkg::VALUE_W-1:0]         rsp_value,
    output logic [tlpq_pkg::LEVEL_W-1:0]         rsp_level,
    output logic [tlpq_pkg::STATUS_W-1:0]        rsp_status
);
    import tlpq_pkg::*;

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SLOTS = LEVELS * DEPTH;
    localparam int AW    = $clog2(SLOTS);

    logic [IW-1:0] head_reg  [LEVELS];
    logic [IW-1:0] head_next [LEVELS];
    logic [IW-1:0] tail_reg  [LEVELS];
    logic [IW-1:0] tail_next [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [CW-1:0] count_next[LEVELS];

    logic [LEVELS-1:0] full;
    logic [LEVELS-1:0] nonempty;

    logic [1:0]          op_q;
    logic                op_wr;
    logic                op_rd;
    logic [LEVEL_W-1:0]  op_level;
    logic [STATUS_W-1:0] op_status;
    logic [IW-1:0]       op_idx;
    logic [AW-1:0]       op_base;
    logic [AW-1:0]       op_addr;

    logic [VALUE_W-1:0]  mem [SLOTS];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                sel_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [STATUS_W-1:0] status_reg;

    // Per-level occupancy flags
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            full[i]     = (count_reg[i] == CW'(DEPTH));
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    // Decode the request: pick the level and the operation
    always_comb begin
        op_q      = 2'd0;
        op_wr     = 1'b0;
        op_rd     = 1'b0;
        op_level  = '0;
        op_status = STATUS_OK;
        if (req_command == CMD_ENQUEUE) begin
            if (req_level != '0) begin
                op_q = req_level - 2'd1;
                if (full[op_q]) begin
                    op_status = STATUS_FULL;
                end else begin
                    op_wr    = 1'b1;
                    op_level = req_level;
                end
            end
        end else begin
            // Strict priority: lowest level number wins
            if (nonempty[0]) begin
                op_q  = 2'd0;
                op_rd = 1'b1;
            end else if (nonempty[1]) begin
                op_q  = 2'd1;
                op_rd = 1'b1;
            end else if (nonempty[2]) begin
                op_q  = 2'd2;
                op_rd = 1'b1;
            end else begin
                op_status = STATUS_EMPTY;
            end
            if (op_rd) begin
                op_level = op_q + 2'd1;
            end
        end
    end

    // Store address: level slice base plus slot within the level
    always_comb begin
        case (op_q)
            2'd0:    op_base = '0;
            2'd1:    op_base = AW'(DEPTH);
            2'd2:    op_base = AW'(2 * DEPTH);
            default: op_base = '0;
        endcase
        op_idx  = op_rd ? head_reg[op_q] : tail_reg[op_q];
        op_addr = op_base + AW'(op_idx);
    end

    // Pointer and count updates
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.exec && (op_q == 2'(i))) begin
                if (op_wr) begin
                    tail_next[i]  = (tail_reg[i] == IW'(DEPTH - 1)) ? '0 : tail_reg[i] + 1'b1;
                    count_next[i] = count_reg[i] + 1'b1;
                end
                if (op_rd) begin
                    head_next[i]  = (head_reg[i] == IW'(DEPTH - 1)) ? '0 : head_reg[i] + 1'b1;
                    count_next[i] = count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Byte store, one port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.exec && op_wr) begin
            mem[op_addr] <= req_value;
        end
        if (cmd.exec && op_rd) begin
            rd_data_reg <= mem[op_addr];
        end
    end

    // Response fields held until the next request
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            sel_reg    <= op_rd;
            level_reg  <= op_level;
            status_reg <= op_status;
        end
    end

    assign rsp_value  = sel_reg ? rd_data_reg : '0;
    assign rsp_level  = level_reg;
    assign rsp_status = status_reg;

endmodule : tlpq_datapath

`default_nettype wire

FILE: rtl/three_level_priority_queue_core.sv
// Top level of the three-level strict-priority byte queue.
// Response: the state and response registers load on the edge that accepts a request,
// so m_tvalid and m_tdata are driven from registers and can be taken after that edge.
// Requests are not overlapped: s_tready is low while a response waits, so a new request
// is taken only after the previous response has been accepted (ST_IDLE, then ST_RESP).
// Reset: aresetn (synchronous, active low) empties all levels; the byte store is not cleared.
`default_nettype none

module three_level_priority_queue_core #(
    parameter int DEPTH = tlpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tlpq_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] item_value,
                                                              // [9:8] priority_level
    input  wire logic                              s_tuser,   // [0] command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tlpq_pkg::M_TDATA_W-1:0]         m_tdata    // [7:0] dequeued_value,
                                                              // [9:8] served_level,
                                                              // [11:10] result_status
);
    import tlpq_pkg::*;

    dp_cmd_t             cmd;
    logic [VALUE_W-1:0]  rsp_value;
    logic [LEVEL_W-1:0]  rsp_level;
    logic [STATUS_W-1:0] rsp_status;

    tlpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tlpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_command (s_tuser),
        .req_value   (s_tdata[7:0]),
        .req_level   (s_tdata[9:8]),
        .rsp_value   (rsp_value),
        .rsp_level   (rsp_level),
        .rsp_status  (rsp_status)
    );

    // Pack the response; upper bits are zero fill
    assign m_tdata = {4'd0, rsp_status, rsp_level, rsp_value};

endmodule : three_level_priority_queue_core

`default_nettype wire
